FILE: design/rlrv_pkg.sv
package rlrv_pkg;

    // Window geometry
    localparam int WINDOW  = 64;
    localparam int PTR_W   = 6;
    localparam int CNT_W   = 7;

    // Field widths
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 32;
    localparam int RC_W    = 12;

    // Arithmetic widths
    localparam int LN_W    = 33;   // ln in Q.28, unsigned
    localparam int RET_W   = 34;   // log return, signed Q.28
    localparam int SUM_W   = 40;   // sum of returns, signed
    localparam int DIV_W   = 48;   // divider dividend and quotient
    localparam int DEN_W   = 6;    // return count divisor

    // ln(2) in Q.30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Saturated volatility
    localparam logic [VOL_W-1:0] VOL_SAT = '1;

endpackage

FILE: design/rlrv_in_if.sv
interface rlrv_in_if;
    logic                            valid;
    logic                            ready;
    logic [rlrv_pkg::PRICE_W-1:0]    mid_price;

    modport source (output valid, output mid_price, input ready);
    modport sink   (input valid, input mid_price, output ready);
endinterface

FILE: design/rlrv_out_if.sv
interface rlrv_out_if;
    logic                            valid;
    logic                            ready;
    logic [rlrv_pkg::VOL_W-1:0]      volatility;
    logic [rlrv_pkg::RC_W-1:0]       return_count;

    modport source (output valid, output volatility, output return_count, input ready);
    modport sink   (input valid, input volatility, input return_count, output ready);
endinterface

FILE: design/rolling_log_return_volatility.sv
// Rolling volatility of log returns over the last 64 mid prices.
// Input channel i_in carries one mid price per beat (zero marks a bad price).
// Output channel o_out carries one beat per input beat: the population
// standard deviation of the window's log returns in unsigned Q4.28 and the
// number of returns used. Fewer than two samples or no valid return gives
// zeros; a volatility of 16 or more saturates to all ones.
// One beat is taken at a time; i_in.ready is high only while idle.
// Per beat the block recomputes the whole window: each stored nonzero price
// goes through the log unit (a zero price skips it), each return gets its
// deviation from the mean, and the mean and variance divisions and the
// square root follow. The log unit runs 30 squaring rounds for every stored
// nonzero price on the one shared 32x32 multiplier.
// The result sits in an output register; if the receiver stalls, the next
// price is still accepted and its result waits until the register frees.
// Reset (i_rst_n low, synchronous) empties the window and drops any
// pending result; no clearing pass is needed.
module rolling_log_return_volatility (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlrv_in_if.sink      i_in,
    rlrv_out_if.source   o_out
);
    import rlrv_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_LD, S_NRM, S_SQ, S_LNA, S_LNB, S_RET,
        S_MDIV, S_MWAIT, S_DRD, S_DEV, S_HL, S_LL, S_HH,
        S_VDIV, S_VWAIT, S_SQRT, S_DONE
    } t_state;

    t_state                    r_state;

    // window bookkeeping
    logic [PTR_W-1:0]          r_wp;
    logic [CNT_W-1:0]          r_cnt;
    logic [PTR_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_k;
    logic [DEN_W-1:0]          r_n;

    // memories
    logic [PRICE_W-1:0]        r_price_mem [WINDOW];
    logic [RET_W-1:0]          r_ret_mem   [WINDOW];
    logic [PRICE_W-1:0]        r_pw_q;
    logic [RET_W-1:0]          r_rb_q;

    // log unit
    logic [PRICE_W-1:0]        r_p;
    logic [31:0]               r_m;
    logic [4:0]                r_e;
    logic [29:0]               r_frac;
    logic [4:0]                r_rnd;
    logic [64:0]               r_acc;
    logic [LN_W-1:0]           r_prev_ln;
    logic                      r_prev_nz;

    // statistics
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [RET_W-1:0]   r_mean;
    logic [RET_W-1:0]          r_u;
    logic [52:0]               r_low;
    logic [DIV_W-1:0]          r_sumsq;

    // square root
    logic [63:0]               r_v;
    logic [63:0]               r_res;
    logic [63:0]               r_bit;
    logic [VOL_W-1:0]          r_vol;

    // output register
    logic                      r_ovalid;
    logic [VOL_W-1:0]          r_out_vol;
    logic [RC_W-1:0]           r_out_rc;
    logic                      w_out_load;

    // next window state on accept
    logic                      w_acc;
    logic [CNT_W-1:0]          n_cnt;
    logic [PTR_W-1:0]          n_wp;

    logic [31:0]               w_mul_a;
    logic [31:0]               w_mul_b;
    logic [63:0]               w_prod;
    logic [32:0]               w_t33;
    logic [LN_W-1:0]           w_ln;
    logic signed [RET_W-1:0]   w_ret;
    logic                      w_ret_ok;
    logic [SUM_W-1:0]          w_sum_abs;
    logic signed [RET_W:0]     w_dev;
    logic [RET_W-1:0]          w_u;
    logic [RET_W-1:0]          w_q34;
    logic [63:0]               w_sq_t;
    logic [63:0]               w_res_n;

    logic                      w_div_start;
    logic [DIV_W-1:0]          w_div_num;
    logic                      w_div_done;
    logic [DIV_W-1:0]          w_div_quo;

    assign w_acc = (r_state == S_IDLE) && i_in.valid;
    assign n_cnt = (r_cnt == CNT_W'(WINDOW)) ? r_cnt : r_cnt + 1'b1;
    assign n_wp  = (r_wp == PTR_W'(WINDOW-1)) ? '0 : r_wp + 1'b1;

    // output register loads once the result is ready and the slot is free
    assign w_out_load = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ: begin
                w_mul_a = r_m;
                w_mul_b = r_m;
            end
            S_LNA: begin
                w_mul_a = {27'd0, r_e};
                w_mul_b = {2'd0, LN2_Q30};
            end
            S_LNB: begin
                w_mul_a = {2'd0, r_frac};
                w_mul_b = {2'd0, LN2_Q30};
            end
            S_HL: begin
                w_mul_a = {14'd0, r_u[33:16]};
                w_mul_b = {16'd0, r_u[15:0]};
            end
            S_LL: begin
                w_mul_a = {16'd0, r_u[15:0]};
                w_mul_b = {16'd0, r_u[15:0]};
            end
            S_HH: begin
                w_mul_a = {14'd0, r_u[33:16]};
                w_mul_b = {14'd0, r_u[33:16]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_t33  = w_prod[63:31];

    // return of the current pair
    assign w_ln     = r_acc[64:32];
    assign w_ret    = $signed({1'b0, w_ln}) - $signed({1'b0, r_prev_ln});
    assign w_ret_ok = (r_k != '0) && r_prev_nz && (r_p != '0);

    // magnitudes for division and deviation
    assign w_sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_q34     = w_div_quo[RET_W-1:0];
    assign w_dev     = $signed({r_rb_q[RET_W-1], r_rb_q}) - $signed({r_mean[RET_W-1], r_mean});
    assign w_u       = w_dev[RET_W] ? RET_W'(-w_dev) : RET_W'(w_dev);

    // square root step
    assign w_sq_t  = r_res + r_bit;
    assign w_res_n = (r_v >= w_sq_t) ? (r_res >> 1) + r_bit : (r_res >> 1);

    // shared divider
    assign w_div_start = (r_state == S_MDIV) || (r_state == S_VDIV);
    assign w_div_num   = (r_state == S_MDIV) ? {8'd0, w_sum_abs} : r_sumsq;

    rlrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_n),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // price window
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_price_mem[r_wp] <= i_in.mid_price;
        end
        r_pw_q <= r_price_mem[r_idx];
    end

    // return buffer
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RET) && w_ret_ok) begin
            r_ret_mem[r_n] <= w_ret;
        end
        r_rb_q <= r_ret_mem[r_k[PTR_W-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_wp      <= n_wp;
                        r_cnt     <= n_cnt;
                        r_idx     <= (n_cnt == CNT_W'(WINDOW)) ? n_wp : '0;
                        r_k       <= '0;
                        r_n       <= '0;
                        r_sum     <= '0;
                        r_sumsq   <= '0;
                        r_prev_nz <= 1'b0;
                        r_vol     <= '0;
                        r_state   <= (n_cnt < CNT_W'(2)) ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_p <= r_pw_q;
                    if (r_pw_q == '0) begin
                        r_acc   <= '0;
                        r_state <= S_RET;
                    end else begin
                        r_m     <= r_pw_q;
                        r_e     <= 5'd31;
                        r_rnd   <= '0;
                        r_state <= S_NRM;
                    end
                end
                // leading-one search, halving the step each cycle
                S_NRM: begin
                    case (r_rnd[2:0])
                        3'd0: if (r_m[31:16] == '0) begin
                            r_m <= r_m << 16;
                            r_e <= r_e - 5'd16;
                        end
                        3'd1: if (r_m[31:24] == '0) begin
                            r_m <= r_m << 8;
                            r_e <= r_e - 5'd8;
                        end
                        3'd2: if (r_m[31:28] == '0) begin
                            r_m <= r_m << 4;
                            r_e <= r_e - 5'd4;
                        end
                        3'd3: if (r_m[31:30] == '0) begin
                            r_m <= r_m << 2;
                            r_e <= r_e - 5'd2;
                        end
                        3'd4: if (r_m[31] == 1'b0) begin
                            r_m <= r_m << 1;
                            r_e <= r_e - 5'd1;
                        end
                        default: begin
                            r_m <= r_m;
                        end
                    endcase
                    if (r_rnd == 5'd4) begin
                        r_rnd   <= '0;
                        r_frac  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                // one fraction bit of log2 per squaring
                S_SQ: begin
                    if (w_t33[32]) begin
                        r_m    <= w_t33[32:1];
                        r_frac <= {r_frac[28:0], 1'b1};
                    end else begin
                        r_m    <= w_t33[31:0];
                        r_frac <= {r_frac[28:0], 1'b0};
                    end
                    if (r_rnd == 5'd29) begin
                        r_state <= S_LNA;
                    end else begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                // ln = (e.frac * ln2) >> 32
                S_LNA: begin
                    r_acc   <= {w_prod[34:0], 30'd0};
                    r_state <= S_LNB;
                end
                S_LNB: begin
                    r_acc   <= r_acc + {1'b0, w_prod};
                    r_state <= S_RET;
                end
                S_RET: begin
                    if (w_ret_ok) begin
                        r_sum <= r_sum + {{(SUM_W-RET_W){w_ret[RET_W-1]}}, w_ret};
                        r_n   <= r_n + 1'b1;
                    end
                    r_prev_ln <= w_ln;
                    r_prev_nz <= (r_p != '0);
                    r_idx     <= (r_idx == PTR_W'(WINDOW-1)) ? '0 : r_idx + 1'b1;
                    if (r_k == r_cnt - 1'b1) begin
                        r_k <= '0;
                        if ((r_n == '0) && !w_ret_ok) begin
                            r_vol   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MDIV;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_MDIV: begin
                    r_state <= S_MWAIT;
                end
                // mean truncates toward zero
                S_MWAIT: begin
                    if (w_div_done) begin
                        r_mean  <= r_sum[SUM_W-1] ? -$signed(w_q34) : $signed(w_q34);
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    r_state <= S_DEV;
                end
                S_DEV: begin
                    r_u     <= w_u;
                    r_state <= S_HL;
                end
                // squared deviation from three partial products
                S_HL: begin
                    r_low   <= {2'd0, w_prod[33:0], 17'd0};
                    r_state <= S_LL;
                end
                S_LL: begin
                    r_low   <= r_low + {21'd0, w_prod[31:0]};
                    r_state <= S_HH;
                end
                S_HH: begin
                    r_sumsq <= r_sumsq + {8'd0, w_prod[35:0], 4'd0}
                               + {23'd0, r_low[52:28]};
                    if (r_k == {1'b0, r_n} - 1'b1) begin
                        r_state <= S_VDIV;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_VDIV: begin
                    r_state <= S_VWAIT;
                end
                S_VWAIT: begin
                    if (w_div_done) begin
                        if (w_div_quo[DIV_W-1:36] != '0) begin
                            r_vol   <= VOL_SAT;
                            r_state <= S_DONE;
                        end else begin
                            r_v     <= {w_div_quo[35:0], 28'd0};
                            r_res   <= '0;
                            r_bit   <= 64'h4000_0000_0000_0000;
                            r_state <= S_SQRT;
                        end
                    end
                end
                // bitwise integer square root
                S_SQRT: begin
                    if (r_v >= w_sq_t) begin
                        r_v <= r_v - w_sq_t;
                    end
                    r_res <= w_res_n;
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_vol   <= w_res_n[VOL_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_vol <= r_vol;
                        r_out_rc  <= {(RC_W-DEN_W)'(0), r_n};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.volatility   = r_out_vol;
    assign o_out.return_count = r_out_rc;

endmodule

FILE: design/rlrv_div.sv
module rlrv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rlrv_pkg::DIV_W-1:0]    i_num,
    input  logic [rlrv_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [rlrv_pkg::DIV_W-1:0]    o_quo
);
    import rlrv_pkg::*;

    logic [DEN_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    r_cnt;
    logic              r_done;

    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
                r_cnt <= (DEN_W+1)'(DIV_W);
            end else if (r_cnt != '0) begin
                r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == (DEN_W+1)'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: verif/rlrv_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the volatility of each price beat and
// compares it with the beats that come out.
module rlrv_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlrv_in_if.sink    i_in,
    rlrv_out_if.sink   i_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count
);
    import rlrv_pkg::*;

    typedef struct packed {
        logic [VOL_W-1:0] volatility;
        logic [RC_W-1:0]  return_count;
    } t_vol_result;

    logic [PRICE_W-1:0] price_ring [WINDOW];
    int unsigned        wr_slot;
    int unsigned        stored;
    t_vol_result        expected_vols [$];

    // Natural log in Q.28 via bitwise log2
    function automatic longint unsigned ln_fixed(input logic [31:0] x);
        int                e;
        longint unsigned   m;
        longint unsigned   frac;
        longint unsigned   a;
        longint unsigned   b;
        frac = 0;
        if (x == 0) return 0;
        e = 31;
        while (x[e] == 1'b0) e--;
        m = longint'(x) << (31 - e);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        a = longint'(e) * LN2_Q30;
        b = frac * LN2_Q30;
        return (a >> 2) + ((((a & 3) << 30) + b) >> 32);
    endfunction

    // floor(u*u / 2^28) without overflow
    function automatic longint unsigned square_q28(input longint unsigned u);
        longint unsigned h;
        longint unsigned l;
        longint unsigned lo;
        h = u >> 16;
        l = u & 64'hFFFF;
        lo = ((2 * h * l) << 16) + l * l;
        return ((h * h) << 4) + (lo >> 28);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Store a price and work out the window's volatility
    function automatic t_vol_result predict_volatility(input logic [PRICE_W-1:0] price);
        t_vol_result       r;
        longint            rets [WINDOW];
        int unsigned       n;
        int unsigned       first;
        int unsigned       idx;
        logic [31:0]       p;
        logic [31:0]       prev_p;
        longint unsigned   cur_ln;
        longint unsigned   prev_ln;
        longint            sum;
        longint            mean;
        longint            d;
        longint unsigned   sumsq;
        longint unsigned   var_q;
        r = '0;
        n = 0;
        sum = 0;
        sumsq = 0;
        prev_p = 0;
        prev_ln = 0;
        price_ring[wr_slot] = price;
        wr_slot = (wr_slot >= WINDOW - 1) ? 0 : wr_slot + 1;
        if (stored < WINDOW) stored++;
        if (stored < 2) return r;
        first = (stored < WINDOW) ? 0 : wr_slot;
        for (int k = 0; k < stored; k++) begin
            idx = (first + k) % WINDOW;
            p = price_ring[idx];
            cur_ln = (p != 0) ? ln_fixed(p) : 0;
            if (k > 0 && p != 0 && prev_p != 0) begin
                rets[n] = longint'(cur_ln) - longint'(prev_ln);
                sum += rets[n];
                n++;
            end
            prev_p = p;
            prev_ln = cur_ln;
        end
        if (n == 0) return r;
        mean = sum / longint'(n);
        for (int k = 0; k < n; k++) begin
            d = rets[k] - mean;
            sumsq += square_q28((d < 0) ? -d : d);
        end
        var_q = sumsq / n;
        if (var_q >= (64'd1 << 36)) r.volatility = VOL_SAT;
        else r.volatility = VOL_W'(int_sqrt(var_q << 28));
        r.return_count = RC_W'(n);
        return r;
    endfunction

    assign o_pending = expected_vols.size();

    // Predict on input beats, check on output beats
    always @(posedge i_clk) begin
        t_vol_result want;
        if (!i_rst_n) begin
            wr_slot <= 0;
            stored <= 0;
            o_fail_count <= 0;
            o_result_count <= 0;
            expected_vols.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_vols.size() == 0) begin
                    $display("%0t: unexpected beat vol=%h rc=%0d", $time,
                             i_out.volatility, i_out.return_count);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_vols.pop_front();
                    if (want.volatility !== i_out.volatility ||
                        want.return_count !== i_out.return_count) begin
                        $display("%0t: mismatch expected vol=%h rc=%0d actual vol=%h rc=%0d",
                                 $time, want.volatility, want.return_count,
                                 i_out.volatility, i_out.return_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // queue the prediction at the tail
            if (i_in.valid && i_in.ready)
                expected_vols.insert(expected_vols.size(),
                                     predict_volatility(i_in.mid_price));
        end
    end

endmodule

FILE: verif/rolling_log_return_volatility_tb.sv
`timescale 1ns / 100ps

module rolling_log_return_volatility_tb;
    import rlrv_pkg::*;

    localparam int  RANDOM_BEATS = 270;
    localparam longint CYCLE_LIMIT = 64'd4_000_000;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending;
    int     result_count;
    int     sent;
    longint cycles;
    logic   rx_stall_mode;

    rlrv_in_if  price_ch ();
    rlrv_out_if vol_ch ();

    rolling_log_return_volatility dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (price_ch.sink),
        .o_out   (vol_ch.source)
    );

    rlrv_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (price_ch.sink),
        .i_out          (vol_ch.sink),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: stalls in phases, sometimes never
    initial begin
        vol_ch.ready = 1'b0;
        rx_stall_mode = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 299) == 0) rx_stall_mode <= ~rx_stall_mode;
            vol_ch.ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // One beat; gaps only between bursts
    task automatic send_price(input logic [PRICE_W-1:0] price);
        price_ch.valid <= 1'b1;
        price_ch.mid_price <= price;
        do @(posedge i_clk); while (!price_ch.ready);
        sent++;
    endtask

    task automatic idle_gap();
        price_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 40)) @(posedge i_clk);
    endtask

    // Random price: mostly a walk around a base, sometimes zero or extreme
    function automatic logic [PRICE_W-1:0] pick_price(input logic [PRICE_W-1:0] last);
        int sel;
        logic [PRICE_W-1:0] p;
        sel = $urandom_range(0, 99);
        if (sel < 6) p = 0;
        else if (sel < 10) p = $urandom;
        else if (sel < 13) p = $urandom_range(1, 15);
        else if (sel < 15) p = 32'hFFFF_FFFF - $urandom_range(0, 15);
        else if (last < 32'h100 || last > 32'hF000_0000) p = 32'h4000_0000 + $urandom_range(0, 65535);
        else p = last + $urandom_range(0, last >> 8) - (last >> 9);
        return p;
    endfunction

    initial begin
        logic [PRICE_W-1:0] last;
        int burst;
        sent = 0;
        last = 32'h4000_0000;
        i_rst_n = 1'b0;
        price_ch.valid = 1'b0;
        price_ch.mid_price = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single sample, zeros, extremes, flat run, saturation
        send_price(32'd1000);
        send_price(32'd0);
        send_price(32'd0);
        send_price(32'd1000);
        send_price(32'd1000);
        send_price(32'd1000);
        send_price(32'hFFFF_FFFF);
        send_price(32'd1);
        send_price(32'hFFFF_FFFF);
        send_price(32'd1);
        send_price(32'h8000_0000);
        send_price(32'h7FFF_FFFF);
        send_price(32'h5555_5555);
        send_price(32'hAAAA_AAAA);
        send_price(32'd2);
        send_price(32'd3);
        idle_gap();

        // Hold off until the block has drained
        price_ch.valid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        // Random bursts; the window wraps several times
        while (sent < 16 + RANDOM_BEATS) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                last = pick_price(last);
                send_price(last);
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
        price_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (4000) @(posedge i_clk);
        $display("Sent %0d prices, checked %0d volatility beats under random stalls",
                 sent, result_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: rolling_log_return_volatility.f
design/rlrv_pkg.sv
design/rlrv_in_if.sv
design/rlrv_out_if.sv
design/rlrv_div.sv
design/rolling_log_return_volatility.sv
verif/rlrv_checker.sv
verif/rolling_log_return_volatility_tb.sv
